### rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition at one edge that implies a consequence at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mrrfc_pkg.sv
// Types and constants of the Modbus RTU request frame checker.
`timescale 1ns / 1ps

package mrrfc_pkg;

	// Configuration port.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 11;

	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_READ_COILS    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_READ_DISCRETE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_READ_HOLDING  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_READ_INPUT    = 3'd3;

	// Reset values of the quantity limits.
	localparam logic [10:0] RST_MAX_READ_COILS    = 11'd2000;
	localparam logic [10:0] RST_MAX_READ_DISCRETE = 11'd2000;
	localparam logic [6:0]  RST_MAX_READ_HOLDING  = 7'd125;
	localparam logic [6:0]  RST_MAX_READ_INPUT    = 7'd125;

	// Function codes.
	localparam logic [7:0] FC_READ_COILS      = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE   = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
	localparam logic [7:0] FC_READ_INPUT      = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
	localparam logic [7:0] FC_WRITE_REGISTER  = 8'd6;
	localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
	localparam logic [7:0] FC_WRITE_REGISTERS = 8'd16;

	// Protocol limits.
	localparam int unsigned LEN_W = 10;
	localparam logic [LEN_W-1:0] LEN_FIXED      = 10'd8;
	localparam logic [LEN_W-1:0] LEN_MULTI_BASE = 10'd9;
	localparam logic [15:0] QTY_MAX_WRITE_COILS = 16'd1968;
	localparam logic [15:0] QTY_MAX_WRITE_REGS  = 16'd123;
	localparam logic [7:0]  STATION_MAX         = 8'd247;
	localparam logic [15:0] COIL_ON             = 16'hFF00;
	localparam logic [15:0] COIL_OFF            = 16'h0000;
	localparam logic [15:0] CRC_INIT            = 16'hFFFF;
	localparam logic [15:0] CRC_POLY            = 16'hA001;

	// Result status codes.
	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_LENGTH     = 4'd1,
		ST_FUNCTION   = 4'd2,
		ST_CRC        = 4'd3,
		ST_STATION    = 4'd4,
		ST_QUANTITY   = 4'd5,
		ST_RANGE      = 4'd6,
		ST_VALUE      = 4'd7,
		ST_BYTE_COUNT = 4'd8
	} status_t;

	// Quantity limits written through the configuration port.
	typedef struct packed {
		logic [10:0] read_coils;
		logic [10:0] read_discrete;
		logic [6:0]  read_holding;
		logic [6:0]  read_input;
	} limits_t;

	// Captured frame contents as seen after the final byte.
	typedef struct packed {
		logic [7:0]  station;
		logic [7:0]  function_code;
		logic [15:0] start;
		logic [15:0] quantity;
		logic [7:0]  declared_count;
		logic [7:0]  padding;
		logic [7:0]  crc_low;
		logic [7:0]  crc_high;
		logic [15:0] crc_expected;
	} frame_fields_t;

endpackage

### rtl/mrrfc_eval.sv
// Status evaluation of a completed request frame.
`timescale 1ns / 1ps

module mrrfc_eval #(
	parameter int unsigned POS_W           = 9,
	parameter int unsigned MIN_FRAME_BYTES = 4,
	parameter int unsigned MAX_FRAME_BYTES = 256
) (
	input  logic [POS_W-1:0]         frame_len,
	input  mrrfc_pkg::frame_fields_t fields,
	input  mrrfc_pkg::limits_t       limits,
	output mrrfc_pkg::status_t       status
);

	localparam logic [POS_W-1:0] MIN_LEN = POS_W'(MIN_FRAME_BYTES);
	localparam logic [POS_W-1:0] MAX_LEN = POS_W'(MAX_FRAME_BYTES);

	// Quantity must be 1..limit, and the last addressed item must stay in 16 bits.
	function automatic mrrfc_pkg::status_t range_status(
		input logic [15:0] start,
		input logic [15:0] quantity,
		input logic [15:0] limit
	);
		logic [16:0] sum;
		mrrfc_pkg::status_t st;
		sum = {1'b0, start} + {1'b0, quantity};
		if (quantity == 16'd0 || quantity > limit) begin
			st = mrrfc_pkg::ST_QUANTITY;
		end else if (sum > 17'h10000) begin
			st = mrrfc_pkg::ST_RANGE;
		end else begin
			st = mrrfc_pkg::ST_OK;
		end
		return st;
	endfunction

	logic [mrrfc_pkg::LEN_W-1:0] len_w;
	logic [mrrfc_pkg::LEN_W-1:0] expect_len;
	logic                        known_fn;
	logic                        len_ok_fn;
	logic                        crc_ok;
	logic                        station_ok;
	logic [16:0]                 qty_plus7;
	logic [2:0]                  pad_shift;
	logic                        pad_bad;
	mrrfc_pkg::status_t          rng_st;
	mrrfc_pkg::status_t          func_st;

	// Shared terms of the checks.
	always_comb begin
		len_w      = mrrfc_pkg::LEN_W'(frame_len);
		expect_len = mrrfc_pkg::LEN_MULTI_BASE + mrrfc_pkg::LEN_W'(fields.declared_count);
		crc_ok     = (fields.crc_low == fields.crc_expected[7:0]) &&
			(fields.crc_high == fields.crc_expected[15:8]);
		station_ok = (fields.station != 8'd0) && (fields.station <= mrrfc_pkg::STATION_MAX);
		qty_plus7  = {1'b0, fields.quantity} + 17'd7;
		pad_shift  = fields.quantity[2:0];
		pad_bad    = (pad_shift != 3'd0) && ((fields.padding & (8'hFF << pad_shift)) != 8'd0);
	end

	// Per-function length rule and function-specific checks.
	always_comb begin
		known_fn  = 1'b1;
		len_ok_fn = (len_w == mrrfc_pkg::LEN_FIXED);
		rng_st    = mrrfc_pkg::ST_OK;
		func_st   = mrrfc_pkg::ST_OK;
		case (fields.function_code)
			mrrfc_pkg::FC_READ_COILS: begin
				func_st = range_status(fields.start, fields.quantity,
					16'(limits.read_coils));
			end
			mrrfc_pkg::FC_READ_DISCRETE: begin
				func_st = range_status(fields.start, fields.quantity,
					16'(limits.read_discrete));
			end
			mrrfc_pkg::FC_READ_HOLDING: begin
				func_st = range_status(fields.start, fields.quantity,
					16'(limits.read_holding));
			end
			mrrfc_pkg::FC_READ_INPUT: begin
				func_st = range_status(fields.start, fields.quantity,
					16'(limits.read_input));
			end
			mrrfc_pkg::FC_WRITE_COIL: begin
				if (fields.quantity != mrrfc_pkg::COIL_OFF &&
					fields.quantity != mrrfc_pkg::COIL_ON) begin
					func_st = mrrfc_pkg::ST_VALUE;
				end
			end
			mrrfc_pkg::FC_WRITE_REGISTER: begin
				func_st = mrrfc_pkg::ST_OK;
			end
			mrrfc_pkg::FC_WRITE_COILS: begin
				len_ok_fn = (len_w >= mrrfc_pkg::LEN_MULTI_BASE) && (len_w == expect_len);
				rng_st = range_status(fields.start, fields.quantity,
					mrrfc_pkg::QTY_MAX_WRITE_COILS);
				if (rng_st != mrrfc_pkg::ST_OK) begin
					func_st = rng_st;
				end else if (fields.declared_count != qty_plus7[10:3]) begin
					func_st = mrrfc_pkg::ST_BYTE_COUNT;
				end else if (pad_bad) begin
					func_st = mrrfc_pkg::ST_VALUE;
				end
			end
			mrrfc_pkg::FC_WRITE_REGISTERS: begin
				len_ok_fn = (len_w >= mrrfc_pkg::LEN_MULTI_BASE) && (len_w == expect_len);
				rng_st = range_status(fields.start, fields.quantity,
					mrrfc_pkg::QTY_MAX_WRITE_REGS);
				if (rng_st != mrrfc_pkg::ST_OK) begin
					func_st = rng_st;
				end else if (fields.declared_count != {fields.quantity[6:0], 1'b0}) begin
					func_st = mrrfc_pkg::ST_BYTE_COUNT;
				end
			end
			default: begin
				known_fn = 1'b0;
			end
		endcase
	end

	// The first failing check in order gives the status.
	always_comb begin
		if (frame_len < MIN_LEN || frame_len > MAX_LEN) begin
			status = mrrfc_pkg::ST_LENGTH;
		end else if (!known_fn) begin
			status = mrrfc_pkg::ST_FUNCTION;
		end else if (!len_ok_fn) begin
			status = mrrfc_pkg::ST_LENGTH;
		end else if (!crc_ok) begin
			status = mrrfc_pkg::ST_CRC;
		end else if (!station_ok) begin
			status = mrrfc_pkg::ST_STATION;
		end else begin
			status = func_st;
		end
	end

endmodule

### rtl/modbus_rtu_request_frame_checker.sv
// Top level of the Modbus RTU request frame checker.
//
// The frame channel (frame_valid, frame_stall) carries one request byte per
// transaction in wire order, with frame_last set on the final byte. The
// result channel (result_valid, result_stall) carries one transaction per
// frame: a status code and the station and function bytes of the frame.
// Bytes without the last mark give no result.
// A byte is registered in the input stage; a non-final byte then updates
// the byte count, the running CRC-16 and the captured header in the next
// cycle. The final byte's status is evaluated as it leaves the input stage
// and lands in the result register, raising result_valid. One byte is
// taken every cycle while frame_stall is low. A stalled result holds, a
// final byte waits in the input stage behind it, and frame_stall rises
// only then, following result_stall directly; other bytes keep flowing.
// Reset clears all frame state and the result channel and loads
// the quantity limits with their maximum values. Configuration writes are
// taken with cfg_we and are meant for idle periods.
`timescale 1ns / 1ps

module modbus_rtu_request_frame_checker #(
	parameter int unsigned MAX_FRAME_BYTES = 256,
	parameter int unsigned MIN_FRAME_BYTES = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             frame_valid,
	output logic                             frame_stall,
	input  logic [7:0]                       frame_byte,
	input  logic                             frame_last,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [3:0]                       status,
	output logic [7:0]                       station_address,
	output logic [7:0]                       function_code,
	input  logic                             cfg_we,
	input  logic [mrrfc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mrrfc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 2);
	localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_FRAME_BYTES + 1);

	// One byte of the reflected CRC-16 with polynomial 0xA001.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ mrrfc_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Frame state.
	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q [2];
	logic [7:0]       tail_q [2];
	logic [7:0]       station_q;
	logic [7:0]       function_q;
	logic [15:0]      start_q;
	logic [15:0]      quantity_q;
	logic [7:0]       count_q;

	// Configuration and result registers.
	mrrfc_pkg::limits_t limits_q;
	logic               result_valid_q;
	mrrfc_pkg::status_t status_q;
	logic [7:0]         station_out_q;
	logic [7:0]         function_out_q;

	// Next-state values.
	logic [POS_W-1:0]         pos_d;
	logic [15:0]              crc_d;
	mrrfc_pkg::frame_fields_t fields_d;
	mrrfc_pkg::status_t       eval_status;
	logic                     blocked;
	logic                     move;
	logic                     accept;

	// Handshake: only a final byte needs the result register free.
	assign blocked     = result_valid_q && result_stall;
	assign move        = valid_s1 && (!last_s1 || !blocked);
	assign frame_stall = valid_s1 && !move;
	assign accept      = frame_valid && !frame_stall;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= frame_byte;
			last_s1 <= frame_last;
		end
	end

	// Field capture by byte position, CRC update and the saturating count.
	always_comb begin
		fields_d.station        = station_q;
		fields_d.function_code  = function_q;
		fields_d.start          = start_q;
		fields_d.quantity       = quantity_q;
		fields_d.declared_count = count_q;
		case (pos_q)
			POS_W'(0): fields_d.station        = byte_s1;
			POS_W'(1): fields_d.function_code  = byte_s1;
			POS_W'(2): fields_d.start[15:8]    = byte_s1;
			POS_W'(3): fields_d.start[7:0]     = byte_s1;
			POS_W'(4): fields_d.quantity[15:8] = byte_s1;
			POS_W'(5): fields_d.quantity[7:0]  = byte_s1;
			POS_W'(6): fields_d.declared_count = byte_s1;
			default: ;
		endcase
		fields_d.padding      = tail_q[0];
		fields_d.crc_low      = tail_q[1];
		fields_d.crc_high     = byte_s1;
		fields_d.crc_expected = crc_q[1];
		crc_d = crc_byte(crc_q[0], byte_s1);
		pos_d = (pos_q < POS_SAT) ? (pos_q + POS_W'(1)) : pos_q;
	end

	mrrfc_eval #(
		.POS_W           (POS_W),
		.MIN_FRAME_BYTES (MIN_FRAME_BYTES),
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_eval (
		.frame_len (pos_d),
		.fields    (fields_d),
		.limits    (limits_q),
		.status    (eval_status)
	);

	// Frame state: advance per byte, clear after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			crc_q[0]   <= mrrfc_pkg::CRC_INIT;
			crc_q[1]   <= mrrfc_pkg::CRC_INIT;
			tail_q[0]  <= 8'd0;
			tail_q[1]  <= 8'd0;
			station_q  <= 8'd0;
			function_q <= 8'd0;
			start_q    <= 16'd0;
			quantity_q <= 16'd0;
			count_q    <= 8'd0;
		end else if (move) begin
			if (last_s1) begin
				pos_q      <= '0;
				crc_q[0]   <= mrrfc_pkg::CRC_INIT;
				crc_q[1]   <= mrrfc_pkg::CRC_INIT;
				tail_q[0]  <= 8'd0;
				tail_q[1]  <= 8'd0;
				station_q  <= 8'd0;
				function_q <= 8'd0;
				start_q    <= 16'd0;
				quantity_q <= 16'd0;
				count_q    <= 8'd0;
			end else begin
				pos_q      <= pos_d;
				crc_q[0]   <= crc_d;
				crc_q[1]   <= crc_q[0];
				tail_q[0]  <= tail_q[1];
				tail_q[1]  <= byte_s1;
				station_q  <= fields_d.station;
				function_q <= fields_d.function_code;
				start_q    <= fields_d.start;
				quantity_q <= fields_d.quantity;
				count_q    <= fields_d.declared_count;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (move && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move && last_s1) begin
			status_q       <= eval_status;
			station_out_q  <= fields_d.station;
			function_out_q <= fields_d.function_code;
		end
	end

	// Quantity limit registers; other indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.read_coils    <= mrrfc_pkg::RST_MAX_READ_COILS;
			limits_q.read_discrete <= mrrfc_pkg::RST_MAX_READ_DISCRETE;
			limits_q.read_holding  <= mrrfc_pkg::RST_MAX_READ_HOLDING;
			limits_q.read_input    <= mrrfc_pkg::RST_MAX_READ_INPUT;
		end else if (cfg_we) begin
			case (cfg_index)
				mrrfc_pkg::CFG_MAX_READ_COILS:    limits_q.read_coils    <= cfg_data;
				mrrfc_pkg::CFG_MAX_READ_DISCRETE: limits_q.read_discrete <= cfg_data;
				mrrfc_pkg::CFG_MAX_READ_HOLDING:  limits_q.read_holding  <= cfg_data[6:0];
				mrrfc_pkg::CFG_MAX_READ_INPUT:    limits_q.read_input    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign result_valid    = result_valid_q;
	assign status          = status_q;
	assign station_address = station_out_q;
	assign function_code   = function_out_q;

endmodule

### rtl/mrrfc_checker.sv
// Port-level assertions for the request frame checker, with the bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrrfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       frame_stall,
	input logic       result_valid,
	input logic       result_stall,
	input logic [3:0] status,
	input logic [7:0] station_address,
	input logic [7:0] function_code
);

	logic station_in_range;
	logic function_listed;

	// Header terms that an ok status requires.
	assign station_in_range = (station_address != 8'd0) &&
		(station_address <= mrrfc_pkg::STATION_MAX);
	assign function_listed = ((function_code >= mrrfc_pkg::FC_READ_COILS) &&
		(function_code <= mrrfc_pkg::FC_WRITE_REGISTER)) ||
		(function_code == mrrfc_pkg::FC_WRITE_COILS) ||
		(function_code == mrrfc_pkg::FC_WRITE_REGISTERS);

	// A stalled result transaction keeps its valid and its status.
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(status) && $stable(station_address), "stalled result changed")

	// Only a pending result can hold back the frame channel.
	`ASSERT_ALWAYS(a_stall_needs_result, clk, arst_n, !result_valid |-> !frame_stall, "frame stalled with empty result register")

	// Status codes stay within the defined set.
	`ASSERT_ALWAYS(a_status_range, clk, arst_n, result_valid |-> status <= 4'(mrrfc_pkg::ST_BYTE_COUNT), "status code out of range")

	// An accepted frame has a valid station and a supported function.
	`ASSERT_ALWAYS(a_ok_header, clk, arst_n, (result_valid && status == 4'(mrrfc_pkg::ST_OK)) |-> (station_in_range && function_listed), "ok status with bad header")

endmodule

bind modbus_rtu_request_frame_checker mrrfc_checker u_mrrfc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.frame_stall     (frame_stall),
	.result_valid    (result_valid),
	.result_stall    (result_stall),
	.status          (status),
	.station_address (station_address),
	.function_code   (function_code)
);
